FILE: hdl/hhfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhfe_pkg
// Shared types and constants of the header hunting frame extractor.
// ----------------------------------------------------------------------------
package hhfe_pkg;

  localparam int DEFAULT_DEPTH = 1024;
  localparam int MIN_FRAME     = 10;
  localparam int MAX_FRAME     = 64;
  localparam int CFG_IDX_W     = 3;

  localparam logic [7:0] RST_HEADER_FIRST   = 8'hAA;
  localparam logic [7:0] RST_HEADER_SECOND  = 8'hBB;
  localparam logic [7:0] RST_SHORT_TYPE     = 8'h01;
  localparam logic [6:0] RST_SHORT_LENGTH   = 7'd10;
  localparam logic [6:0] RST_LONG_LENGTH    = 7'd11;
  localparam logic [7:0] RST_TRAILER_FIRST  = 8'hAA;
  localparam logic [7:0] RST_TRAILER_SECOND = 8'hBB;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST   = 3'd0,
    REG_HEADER_SECOND  = 3'd1,
    REG_SHORT_TYPE     = 3'd2,
    REG_SHORT_LENGTH   = 3'd3,
    REG_LONG_LENGTH    = 3'd4,
    REG_TRAILER_FIRST  = 3'd5,
    REG_TRAILER_SECOND = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] short_type_code;
    logic [6:0] short_length;
    logic [6:0] long_length;
    logic [7:0] trailer_first;
    logic [7:0] trailer_second;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HUNT,
    ST_HDR0,
    ST_HDR1,
    ST_LEN,
    ST_TRL0,
    ST_TRL1,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/hhfe_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhfe_if
// Valid/ready channels: raw byte stream in, frame bytes out, register writes.
// ----------------------------------------------------------------------------
interface hhfe_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface hhfe_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_offset;
  logic       last_byte;
  modport source (output valid, output frame_byte, output byte_offset, output last_byte,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_offset, input last_byte,
                  output ready);
endinterface

interface hhfe_cfg_if import hhfe_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/hhfe_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhfe_ring
// Byte ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hhfe_ring import hhfe_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] waddr,
  input  logic [7:0]                      wdata,
  input  logic                            re,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] raddr,
  output logic [7:0]                      rdata
);

  logic [7:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hhfe_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhfe_cfg
// Configuration register file with reset values.
// ----------------------------------------------------------------------------
module hhfe_cfg import hhfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hhfe_cfg_if.sink    cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.header_first    <= RST_HEADER_FIRST;
      regs.header_second   <= RST_HEADER_SECOND;
      regs.short_type_code <= RST_SHORT_TYPE;
      regs.short_length    <= RST_SHORT_LENGTH;
      regs.long_length     <= RST_LONG_LENGTH;
      regs.trailer_first   <= RST_TRAILER_FIRST;
      regs.trailer_second  <= RST_TRAILER_SECOND;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HEADER_FIRST:   regs.header_first    <= cfg.data;
        REG_HEADER_SECOND:  regs.header_second   <= cfg.data;
        REG_SHORT_TYPE:     regs.short_type_code <= cfg.data;
        REG_SHORT_LENGTH:   regs.short_length    <= cfg.data[6:0];
        REG_LONG_LENGTH:    regs.long_length     <= cfg.data[6:0];
        REG_TRAILER_FIRST:  regs.trailer_first   <= cfg.data;
        REG_TRAILER_SECOND: regs.trailer_second  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hhfe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhfe_ctrl
// Ring pointers, header hunt, length and trailer check, frame read-out.
// ----------------------------------------------------------------------------
module hhfe_ctrl import hhfe_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  hhfe_stream_if.sink                     stream,
  hhfe_frame_if.source                    frame,
  input  cfg_t                            regs,
  output logic                            ring_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ring_waddr,
  output logic [7:0]                      ring_wdata,
  output logic                            ring_re,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ring_raddr,
  input  logic [7:0]                      ring_rdata
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(BUFFER_DEPTH);
  localparam logic [FW-1:0] FULL    = FW'(BUFFER_DEPTH);

  state_t        state, state_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [FW-1:0] fill, fill_next;
  logic          final_hunt, final_hunt_next;
  logic [7:0]    hold, hold_next;
  logic [6:0]    size, size_next;
  logic [5:0]    k, k_next;
  logic          out_valid, out_valid_next;
  logic [7:0]    out_byte, out_byte_next;
  logic [5:0]    out_off, out_off_next;
  logic          out_last, out_last_next;
  logic [6:0]    len_sel, len_clamped;
  logic [5:0]    size_m1;

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [6:0] off);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(off);
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  assign len_sel = (ring_rdata == regs.short_type_code) ? regs.short_length
                                                         : regs.long_length;
  assign len_clamped = (len_sel < 7'(MIN_FRAME)) ? 7'(MIN_FRAME) :
                       (len_sel > 7'(MAX_FRAME)) ? 7'(MAX_FRAME) : len_sel;
  assign size_m1 = 6'(size - 7'd1);

  assign stream.ready      = (state == ST_IDLE);
  assign frame.valid       = out_valid;
  assign frame.frame_byte  = out_byte;
  assign frame.byte_offset = out_off;
  assign frame.last_byte   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      fill       <= '0;
      final_hunt <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_ptr     <= rd_ptr_next;
      wr_ptr     <= wr_ptr_next;
      fill       <= fill_next;
      final_hunt <= final_hunt_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold     <= hold_next;
    size     <= size_next;
    k        <= k_next;
    out_byte <= out_byte_next;
    out_off  <= out_off_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    fill_next       = fill;
    final_hunt_next = final_hunt;
    hold_next       = hold;
    size_next       = size;
    k_next          = k;
    out_valid_next  = out_valid && !frame.ready;
    out_byte_next   = out_byte;
    out_off_next    = out_off;
    out_last_next   = out_last;
    ring_we         = 1'b0;
    ring_waddr      = wr_ptr;
    ring_wdata      = stream.stream_byte;
    ring_re         = 1'b0;
    ring_raddr      = rd_ptr;

    case (state)
      ST_IDLE: begin
        if (stream.valid) begin
          ring_we     = 1'b1;
          wr_ptr_next = ptr_add(wr_ptr, 7'd1);
          // full ring: overwrite the oldest byte, fill stays put
          if (fill == FULL) begin
            rd_ptr_next = ptr_add(rd_ptr, 7'd1);
          end else begin
            fill_next = fill + FW'(1);
          end
          final_hunt_next = 1'b0;
          state_next      = ST_HUNT;
        end
      end
      ST_HUNT: begin
        if (fill < FW'(2)) begin
          state_next = ST_IDLE;
        end else begin
          ring_re    = 1'b1;
          ring_raddr = rd_ptr;
          state_next = ST_HDR0;
        end
      end
      ST_HDR0: begin
        hold_next  = ring_rdata;
        ring_re    = 1'b1;
        ring_raddr = ptr_add(rd_ptr, 7'd1);
        state_next = ST_HDR1;
      end
      ST_HDR1: begin
        if (hold == regs.header_first && ring_rdata == regs.header_second) begin
          if (final_hunt || fill < FW'(3)) begin
            state_next = ST_IDLE;
          end else begin
            ring_re    = 1'b1;
            ring_raddr = ptr_add(rd_ptr, 7'd2);
            state_next = ST_LEN;
          end
        end else begin
          rd_ptr_next = ptr_add(rd_ptr, 7'd1);
          fill_next   = fill - FW'(1);
          state_next  = ST_HUNT;
        end
      end
      ST_LEN: begin
        size_next = len_clamped;
        if (fill < FW'(len_clamped)) begin
          state_next = ST_IDLE;
        end else begin
          ring_re    = 1'b1;
          ring_raddr = ptr_add(rd_ptr, 7'd8);
          state_next = ST_TRL0;
        end
      end
      ST_TRL0: begin
        hold_next  = ring_rdata;
        ring_re    = 1'b1;
        ring_raddr = ptr_add(rd_ptr, 7'd9);
        state_next = ST_TRL1;
      end
      ST_TRL1: begin
        if (hold == regs.trailer_first && ring_rdata == regs.trailer_second) begin
          ring_re    = 1'b1;
          ring_raddr = rd_ptr;
          k_next     = '0;
          state_next = ST_EMIT;
        end else begin
          // bad trailer: drop one byte, hunt once more, then stop
          rd_ptr_next     = ptr_add(rd_ptr, 7'd1);
          fill_next       = fill - FW'(1);
          final_hunt_next = 1'b1;
          state_next      = ST_HUNT;
        end
      end
      ST_EMIT: begin
        // read data holds while the output slot is blocked
        if (!out_valid || frame.ready) begin
          out_valid_next = 1'b1;
          out_byte_next  = ring_rdata;
          out_off_next   = k;
          out_last_next  = (k == size_m1);
          if (k == size_m1) begin
            rd_ptr_next = ptr_add(rd_ptr, size);
            fill_next   = fill - FW'(size);
            state_next  = ST_IDLE;
          end else begin
            k_next     = k + 6'd1;
            ring_re    = 1'b1;
            ring_raddr = ptr_add(rd_ptr, 7'(k) + 7'd1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  logic [FW:0] chk_sum;
  assign chk_sum = (FW+1)'(rd_ptr) + (FW+1)'(fill);

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count beyond ring depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |->
      (chk_sum == (FW+1)'(wr_ptr) ||
       chk_sum == (FW+1)'(wr_ptr) + (FW+1)'(BUFFER_DEPTH)))
    else $error("read pointer, fill and write pointer disagree");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    stream.valid && stream.ready |=> fill != '0)
    else $error("accepted item left ring empty");

  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(state) == ST_EMIT)
    else $error("output loaded outside frame read-out");

  a_emit_buffered: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> fill >= FW'(size))
    else $error("read-out of a frame not fully buffered");
`endif

endmodule
`default_nettype wire

FILE: hdl/header_hunting_frame_extractor_unit.sv
`default_nettype none
// An item is taken only in idle; no other is taken until the block is back in idle. Each header
//   test is a fill check and two ring reads, and every byte the hunt drops costs one more test.
// A full frame check (header, length, trailer) runs hunt, hdr0, hdr1, len, trl0, trl1; read-out
//   then moves one frame byte per cycle from the ring read port while the sink takes them.
// Reset (rst, synchronous): pointers and fill clear, registers take defaults; ring contents
//   are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// header_hunting_frame_extractor_unit
// Byte stream deframer: ring buffer, header hunt, trailer check, frame output.
// ----------------------------------------------------------------------------
module header_hunting_frame_extractor_unit import hhfe_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  hhfe_stream_if.sink  stream,
  hhfe_frame_if.source frame,
  hhfe_cfg_if.sink     cfg
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  cfg_t          regs;
  logic          ring_we;
  logic [AW-1:0] ring_waddr;
  logic [7:0]    ring_wdata;
  logic          ring_re;
  logic [AW-1:0] ring_raddr;
  logic [7:0]    ring_rdata;

  hhfe_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  hhfe_ring #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  hhfe_ctrl #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .frame      (frame),
    .regs       (regs),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .ring_re    (ring_re),
    .ring_raddr (ring_raddr),
    .ring_rdata (ring_rdata)
  );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the header hunting frame extractor. A behavioral
// deframer runs beside the block and queues every frame byte it should emit.
// A monitor compares each emitted byte against that queue. Traffic starts with
// a hand-built byte sequence at the default registers. It then runs frames at
// the length limits, then random frames, noise and broken frames under random
// register settings, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import hhfe_pkg::*;

  localparam int RING_DEPTH    = DEFAULT_DEPTH;
  localparam int NUM_REGS      = int'(REG_TRAILER_SECOND) + 1;
  localparam int RANDOM_ITEMS  = 40;
  localparam int RANDOM_PHASES = 5;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic [7:0] frame_byte;
    logic [5:0] byte_offset;
    logic       last_byte;
  } frame_beat_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic clk;
  logic rst;

  hhfe_stream_if stream_ch ();
  hhfe_frame_if  frame_ch ();
  hhfe_cfg_if    cfg_ch ();

  header_hunting_frame_extractor_unit #(.BUFFER_DEPTH(RING_DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .frame  (frame_ch),
    .cfg    (cfg_ch)
  );

  // Deframer state and the frame bytes it still expects from the block
  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned rd_ptr;
  int unsigned wr_ptr;
  int unsigned fill_cnt;
  cfg_t        model_cfg;
  frame_beat_t beats_due [$];

  int unsigned bytes_sent;
  int unsigned beats_checked;
  int unsigned frames_seen;
  int unsigned error_count;
  int unsigned settings_used;
  int unsigned cycle_count;
  int          burst_left;
  int          mode_left;
  int          stall_left;
  rx_mode_t    rx_mode;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] ring_at(int unsigned pos);
    return ring_mem[(rd_ptr + pos) % RING_DEPTH];
  endfunction

  function automatic void drop_front();
    if (fill_cnt > 0) begin
      rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      fill_cnt--;
    end
  endfunction

  function automatic bit seek_header();
    while (fill_cnt >= 2) begin
      if (ring_at(0) == model_cfg.header_first && ring_at(1) == model_cfg.header_second)
        return 1'b1;
      drop_front();
    end
    return 1'b0;
  endfunction

  function automatic int unsigned clamp_size(logic [6:0] len);
    if (len < MIN_FRAME) return MIN_FRAME;
    if (len > MAX_FRAME) return MAX_FRAME;
    return len;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    int unsigned size;
    frame_beat_t beat;
    if (fill_cnt >= RING_DEPTH) drop_front();
    ring_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    fill_cnt++;
    if (!seek_header() || fill_cnt < 3) return;
    size = clamp_size(ring_at(2) == model_cfg.short_type_code ?
                      model_cfg.short_length : model_cfg.long_length);
    if (fill_cnt < size) return;
    // Bad trailer: slip one byte and hunt again
    if (ring_at(8) != model_cfg.trailer_first || ring_at(9) != model_cfg.trailer_second) begin
      drop_front();
      void'(seek_header());
      return;
    end
    for (int unsigned k = 0; k < size; k++) begin
      beat.frame_byte  = ring_at(k);
      beat.byte_offset = k[5:0];
      beat.last_byte   = (k + 1 == size);
      beats_due.push_back(beat);
    end
    rd_ptr   = (rd_ptr + size) % RING_DEPTH;
    fill_cnt -= size;
  endfunction

  function automatic void set_model_reg(cfg_reg_t idx, logic [7:0] value);
    case (idx)
      REG_HEADER_FIRST:   model_cfg.header_first    = value;
      REG_HEADER_SECOND:  model_cfg.header_second   = value;
      REG_SHORT_TYPE:     model_cfg.short_type_code = value;
      REG_SHORT_LENGTH:   model_cfg.short_length    = value[6:0];
      REG_LONG_LENGTH:    model_cfg.long_length     = value[6:0];
      REG_TRAILER_FIRST:  model_cfg.trailer_first   = value;
      REG_TRAILER_SECOND: model_cfg.trailer_second  = value;
      default: ;
    endcase
  endfunction

  function automatic void check_beat();
    frame_beat_t want;
    if (beats_due.size() == 0) begin
      error_count++;
      $display("%0t: unexpected frame byte: expected none, actual %02h offset %0d last %0b",
               $time, frame_ch.frame_byte, frame_ch.byte_offset, frame_ch.last_byte);
      return;
    end
    want = beats_due.pop_front();
    beats_checked++;
    if (frame_ch.last_byte === 1'b1) frames_seen++;
    if (frame_ch.frame_byte !== want.frame_byte) begin
      error_count++;
      $display("%0t: frame_byte mismatch: expected %02h actual %02h",
               $time, want.frame_byte, frame_ch.frame_byte);
    end
    if (frame_ch.byte_offset !== want.byte_offset) begin
      error_count++;
      $display("%0t: byte_offset mismatch: expected %0d actual %0d",
               $time, want.byte_offset, frame_ch.byte_offset);
    end
    if (frame_ch.last_byte !== want.last_byte) begin
      error_count++;
      $display("%0t: last_byte mismatch: expected %0b actual %0b",
               $time, want.last_byte, frame_ch.last_byte);
    end
  endfunction

  // Frame monitor and output back-pressure
  initial begin
    frame_ch.ready <= 1'b0;
    mode_left  = 0;
    stall_left = 0;
    rx_mode    = RX_OPEN;
    forever begin
      @(posedge clk);
      if (!rst && frame_ch.valid && frame_ch.ready) check_beat();
      if (mode_left <= 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   frame_ch.ready <= 1'b1;
        RX_RANDOM: frame_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            frame_ch.ready <= 1'b0;
          end else begin
            frame_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frame bytes still expected",
               cycle_count, beats_due.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (burst_left <= 0) begin
      stream_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    stream_ch.valid       <= 1'b1;
    stream_ch.stream_byte <= b;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
    deframe_byte(b);
  endtask

  // Hold off until every expected byte is out and any hunt has finished
  task automatic drain_and_settle();
    stream_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] vals [NUM_REGS]);
    cfg_reg_t idx;
    drain_and_settle();
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = cfg_reg_t'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      set_model_reg(idx, vals[i]);
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Build a frame for the current registers; keep limits how many bytes go out
  task automatic send_frame(input bit short_type, input bit good_trailer,
                            input int unsigned keep);
    logic [7:0]  body [MAX_FRAME];
    logic [7:0]  type_byte;
    int unsigned size;
    type_byte = 8'($urandom_range(0, 255));
    if (short_type) type_byte = model_cfg.short_type_code;
    else if (type_byte == model_cfg.short_type_code) type_byte = type_byte + 8'd1;
    size = clamp_size(short_type ? model_cfg.short_length : model_cfg.long_length);
    for (int unsigned k = 0; k < size; k++) body[k] = 8'($urandom_range(0, 255));
    body[0] = model_cfg.header_first;
    body[1] = model_cfg.header_second;
    body[2] = type_byte;
    body[8] = model_cfg.trailer_first;
    body[9] = model_cfg.trailer_second;
    if (!good_trailer) begin
      if ($urandom_range(0, 1) != 0) body[8] = ~model_cfg.trailer_first;
      else body[9] = ~model_cfg.trailer_second;
    end
    for (int unsigned k = 0; k < size && k < keep; k++) push_byte(body[k]);
  endtask

  task automatic run_random_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) send_frame(1'($urandom_range(0, 1)), 1'b1, MAX_FRAME);
      else if (pick < 75) send_frame(1'($urandom_range(0, 1)), 1'b0, MAX_FRAME);
      else if (pick < 85) send_frame(1'($urandom_range(0, 1)), 1'b1, $urandom_range(1, 9));
      else repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Default registers: noise, header with no type byte yet, a good short
  // frame, then a long frame whose trailer is wrong
  task automatic test_directed_defaults();
    logic [7:0] seq [23] = '{
      8'h00, 8'hFF,
      8'hAA, 8'hBB, 8'h01, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h7F, 8'hAA, 8'hBB,
      8'hAA, 8'hBB, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h00, 8'hBB, 8'h66
    };
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  // Lengths below and above the legal range, exact maximum, extreme codes
  task automatic test_length_limits();
    // order: header first/second, type, short, long, trailer first/second
    logic [7:0] low_high [NUM_REGS] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
    logic [7:0] max_min  [NUM_REGS] = '{8'hFF, 8'h00, 8'h00, 8'd64, 8'd9, 8'h00, 8'hFF};
    load_config(low_high);
    send_frame(1'b1, 1'b1, MAX_FRAME);
    send_frame(1'b0, 1'b1, MAX_FRAME);
    send_frame(1'b1, 1'b0, MAX_FRAME);
    load_config(max_min);
    send_frame(1'b0, 1'b1, MAX_FRAME);
    send_frame(1'b0, 1'b0, MAX_FRAME);
    // leave a partial short-type frame for the next setting to hunt past
    send_frame(1'b1, 1'b1, 12);
  endtask

  task automatic test_random_settings();
    logic [7:0] vals [NUM_REGS];
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      foreach (vals[i]) vals[i] = 8'($urandom_range(0, 255));
      // keep lengths short except in one phase; bit 7 is don't-care
      if (p != RANDOM_PHASES - 2) begin
        vals[REG_SHORT_LENGTH] = 8'($urandom_range(10, 16) + 128 * $urandom_range(0, 1));
        vals[REG_LONG_LENGTH]  = 8'($urandom_range(10, 16) + 128 * $urandom_range(0, 1));
      end
      load_config(vals);
      run_random_traffic(RANDOM_ITEMS / RANDOM_PHASES);
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    stream_ch.valid       <= 1'b0;
    stream_ch.stream_byte <= 8'h00;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_HEADER_FIRST;
    cfg_ch.data           <= 8'h00;
    rd_ptr        = 0;
    wr_ptr        = 0;
    fill_cnt      = 0;
    bytes_sent    = 0;
    beats_checked = 0;
    frames_seen   = 0;
    error_count   = 0;
    settings_used = 1;
    cycle_count   = 0;
    burst_left    = 0;
    model_cfg.header_first    = RST_HEADER_FIRST;
    model_cfg.header_second   = RST_HEADER_SECOND;
    model_cfg.short_type_code = RST_SHORT_TYPE;
    model_cfg.short_length    = RST_SHORT_LENGTH;
    model_cfg.long_length     = RST_LONG_LENGTH;
    model_cfg.trailer_first   = RST_TRAILER_FIRST;
    model_cfg.trailer_second  = RST_TRAILER_SECOND;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_defaults();
    test_length_limits();
    test_random_settings();
    drain_and_settle();

    $display("Sent %0d stream bytes across %0d register settings.", bytes_sent, settings_used);
    $display("Checked %0d frame bytes in %0d frames, %0d errors.",
             beats_checked, frames_seen, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
